[hdl/roulette_wheel_selection_macros.svh]
// ---------------------------------------------------------------------------
// Roulette wheel selection: assertion macros
// Concurrent check wrappers, removed when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ROULETTE_WHEEL_SELECTION_MACROS_SVH
`define ROULETTE_WHEEL_SELECTION_MACROS_SVH

`ifndef SYNTHESIS
`define RWS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define RWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RWS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define RWS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

[hdl/rws_pkg.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: package
// Field widths, constants, command and state types.
// ---------------------------------------------------------------------------
package rws_pkg;

   localparam int CFG_W              = 6;
   localparam int FIT_W              = 21;
   localparam int DRAW_W             = 10;
   localparam int SEL_W              = 5;
   localparam int SUM_W              = 26;
   localparam int PROD_W             = DRAW_W + SUM_W;
   localparam int SCALE              = 1000;
   localparam int DEF_MAX_POPULATION = 32;
   localparam int RESET_POPULATION   = 25;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type        kind;
      logic                restart;
      logic [FIT_W-1:0]    fitness_value;
      logic [DRAW_W-1:0]   draw;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TOTAL,
      ST_PROBE_ADDR,
      ST_PROBE_CMP,
      ST_RESULT
   } back_state_type;

endpackage

[hdl/rws_channel_if.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: channel interfaces
// Request, response and register write channels with valid/ready.
// ---------------------------------------------------------------------------
interface rws_req_if import rws_pkg::*;;
   logic              valid;
   logic              ready;
   logic              mode;
   logic              restart;
   logic [FIT_W-1:0]  fitness_value;
   logic [DRAW_W-1:0] draw;

   modport source (output valid, mode, restart, fitness_value, draw, input ready);
   modport sink   (input valid, mode, restart, fitness_value, draw, output ready);
endinterface

interface rws_rsp_if import rws_pkg::*;;
   logic             valid;
   logic             ready;
   logic [SEL_W-1:0] selected_index;
   logic             zero_total;

   modport source (output valid, selected_index, zero_total, input ready);
   modport sink   (input valid, selected_index, zero_total, output ready);
endinterface

interface rws_csr_if import rws_pkg::*;;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] population_count;

   modport source (output valid, population_count, input ready);
   modport sink   (input valid, population_count, output ready);
endinterface

[hdl/rws_front.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: front end
// Holds the population register, clamps it and decodes requests.
// ---------------------------------------------------------------------------
module rws_front import rws_pkg::*; #(
   parameter int MAX_POPULATION = DEF_MAX_POPULATION,
   localparam int CNT_W = $clog2(MAX_POPULATION + 1)
) (
   input  logic              clock,
   input  logic              reset,
   rws_req_if.sink           req_chan,
   rws_csr_if.sink           csr_chan,
   output logic              push_valid,
   input  logic              push_ready,
   output cmd_type           push_cmd,
   output logic [CNT_W-1:0]  eff_count
);

   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   logic [CFG_W-1:0] pop_count_ff;
   logic [CFG_W-1:0] pop_count_in;
   logic [CMP_W-1:0] pop_ext;

   assign csr_chan.ready = 1'b1;
   assign pop_count_in   = (csr_chan.valid) ? csr_chan.population_count : pop_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pop_count_ff <= CFG_W'(RESET_POPULATION);
      end else begin
         pop_count_ff <= pop_count_in;
      end
   end

   assign pop_ext   = CMP_W'(pop_count_ff);
   assign eff_count = (pop_ext >= CMP_W'(MAX_POPULATION)) ?
                      CNT_W'(MAX_POPULATION) : CNT_W'(pop_ext);

   always_comb begin
      push_cmd.kind          = (req_chan.mode) ? CMD_DRAW : CMD_LOAD;
      push_cmd.restart       = req_chan.restart & ~req_chan.mode;
      push_cmd.fitness_value = req_chan.fitness_value;
      push_cmd.draw          = req_chan.draw;
   end

   assign push_valid     = req_chan.valid;
   assign req_chan.ready = push_ready;

endmodule

[hdl/rws_queue.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: command queue
// Two-entry register FIFO between front end and engine.
// ---------------------------------------------------------------------------
module rws_queue import rws_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   `include "roulette_wheel_selection_macros.svh"

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             push;
   logic             pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   `RWS_ASSERT_IMPL(a_queue_bound, clock, reset, 1'b1, (count_ff <= CNT_W'(QUEUE_DEPTH)), "queue over depth")
   `RWS_ASSERT_NEXT(a_queue_fill, clock, reset, (push && !pop && count_ff == '0), (pop_valid), "queue lost entry")

endmodule

[hdl/rws_back.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: engine
// Cumulative sum memory, load path, binary search and response register.
// ---------------------------------------------------------------------------
module rws_back import rws_pkg::*; #(
   parameter int MAX_POPULATION = DEF_MAX_POPULATION,
   localparam int CNT_W = $clog2(MAX_POPULATION + 1),
   localparam int IDX_W = $clog2(MAX_POPULATION)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  cmd_type          pop_cmd,
   input  logic [CNT_W-1:0] eff_count,
   rws_rsp_if.source        rsp_chan
);

   `include "roulette_wheel_selection_macros.svh"

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [CNT_W-1:0]  loaded_ff;
   logic [CNT_W-1:0]  loaded_in;
   logic [SUM_W-1:0]  last_sum_ff;
   logic [SUM_W-1:0]  last_sum_in;
   logic [IDX_W-1:0]  lo_ff;
   logic [IDX_W-1:0]  lo_in;
   logic [IDX_W-1:0]  hi_ff;
   logic [IDX_W-1:0]  hi_in;
   logic [IDX_W-1:0]  mid_ff;
   logic [IDX_W-1:0]  mid_in;
   logic [DRAW_W-1:0] draw_ff;
   logic [DRAW_W-1:0] draw_in;
   logic [PROD_W-1:0] point_ff;
   logic [PROD_W-1:0] point_in;
   logic              zero_ff;
   logic              zero_in;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [SEL_W-1:0]  rsp_idx_ff;
   logic [SEL_W-1:0]  rsp_idx_in;
   logic              rsp_zero_ff;
   logic              rsp_zero_in;
   logic [SUM_W-1:0]  mem_ff [MAX_POPULATION];
   logic [SUM_W-1:0]  rd_data_ff;

   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic [SUM_W-1:0]  mem_wdata;
   logic              mem_re;
   logic [IDX_W-1:0]  mem_raddr;

   logic [CNT_W-1:0]  base;
   logic [SUM_W-1:0]  prev;
   logic [SUM_W:0]    sum_wide;
   logic [SUM_W-1:0]  sum_sat;
   logic [CNT_W-1:0]  n;
   logic [IDX_W-1:0]  n_last;
   logic [IDX_W:0]    mid_sum;
   logic [PROD_W-1:0] scaled;
   logic              slot_free;

   assign pop_ready = (state_ff == ST_IDLE);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign base     = (pop_cmd.restart) ? '0 : loaded_ff;
   assign prev     = (base == '0) ? '0 : last_sum_ff;
   assign sum_wide = (SUM_W+1)'(prev) + (SUM_W+1)'(pop_cmd.fitness_value);
   assign sum_sat  = (sum_wide[SUM_W]) ? SUM_MAX : sum_wide[SUM_W-1:0];
   assign n        = (loaded_ff < eff_count) ? loaded_ff : eff_count;
   assign n_last   = IDX_W'(n - 1'b1);
   assign mid_sum  = (IDX_W+1)'(lo_ff) + (IDX_W+1)'(hi_ff);
   assign scaled   = PROD_W'(rd_data_ff) * PROD_W'(SCALE);

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      last_sum_in  = last_sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mid_in       = mid_ff;
      draw_in      = draw_ff;
      point_in     = point_ff;
      zero_in      = zero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_zero_in  = rsp_zero_ff;
      mem_we       = 1'b0;
      mem_waddr    = IDX_W'(base);
      mem_wdata    = sum_sat;
      mem_re       = 1'b0;
      mem_raddr    = n_last;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               if (pop_cmd.kind == CMD_LOAD) begin
                  loaded_in = base;
                  if (base < eff_count) begin
                     mem_we      = 1'b1;
                     last_sum_in = sum_sat;
                     loaded_in   = base + 1'b1;
                  end
               end else begin
                  draw_in = pop_cmd.draw;
                  lo_in   = '0;
                  hi_in   = n_last;
                  zero_in = (n == '0);
                  if (n == '0) begin
                     state_in = ST_RESULT;
                  end else begin
                     mem_re   = 1'b1;
                     state_in = ST_TOTAL;
                  end
               end
            end
         end
         ST_TOTAL: begin
            if (rd_data_ff == '0) begin
               zero_in  = 1'b1;
               state_in = ST_RESULT;
            end else begin
               point_in = PROD_W'(draw_ff) * PROD_W'(rd_data_ff);
               state_in = ST_PROBE_ADDR;
            end
         end
         ST_PROBE_ADDR: begin
            if (lo_ff == hi_ff) begin
               state_in = ST_RESULT;
            end else begin
               mid_in    = mid_sum[IDX_W:1];
               mem_re    = 1'b1;
               mem_raddr = mid_sum[IDX_W:1];
               state_in  = ST_PROBE_CMP;
            end
         end
         ST_PROBE_CMP: begin
            if (point_ff < scaled) begin
               hi_in = mid_ff;
            end else begin
               lo_in = mid_ff + 1'b1;
            end
            state_in = ST_PROBE_ADDR;
         end
         ST_RESULT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = (zero_ff) ? '0 : SEL_W'(lo_ff);
               rsp_zero_in  = zero_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         loaded_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_sum_ff <= last_sum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      draw_ff     <= draw_in;
      point_ff    <= point_in;
      zero_ff     <= zero_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_zero_ff <= rsp_zero_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[mem_raddr];
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.selected_index = rsp_idx_ff;
   assign rsp_chan.zero_total     = rsp_zero_ff;

   `RWS_ASSERT_IMPL(a_search_order, clock, reset, (state_ff == ST_PROBE_ADDR), (lo_ff <= hi_ff), "search bounds crossed")
   `RWS_ASSERT_IMPL(a_loaded_bound, clock, reset, 1'b1, (loaded_ff <= CNT_W'(MAX_POPULATION)), "loaded count over limit")
   `RWS_ASSERT_IMPL(a_zero_index, clock, reset, (rsp_valid_ff && rsp_zero_ff), (rsp_idx_ff == '0), "zero total with nonzero index")

endmodule

[hdl/roulette_wheel_selection.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: top level
// Loads fitness values into a cumulative sum wheel and answers draws.
//
//   channel   dir   payload                                  handshake
//   req_chan  in    mode, restart, fitness_value, draw       valid/ready
//   rsp_chan  out   selected_index, zero_total               valid/ready
//   csr_chan  in    population_count                         valid/ready
//
// A load is handled in the engine's idle state. A draw over n entries reads the
// total from memory, multiplies it by the draw, then does a read and a compare
// per binary search step on the single read port of the sum memory.
// Reset is synchronous; it clears the wheel count, the queue and the response.
// A two-entry queue lets requests arrive while the engine or response stalls.
// ---------------------------------------------------------------------------
module roulette_wheel_selection import rws_pkg::*; #(
   parameter int MAX_POPULATION = DEF_MAX_POPULATION
) (
   input  logic      clock,
   input  logic      reset,
   rws_req_if.sink   req_chan,
   rws_rsp_if.source rsp_chan,
   rws_csr_if.sink   csr_chan
);

   localparam int CNT_W = $clog2(MAX_POPULATION + 1);

   logic             push_valid;
   logic             push_ready;
   cmd_type          push_cmd;
   logic             pop_valid;
   logic             pop_ready;
   cmd_type          pop_cmd;
   logic [CNT_W-1:0] eff_count;

   rws_front #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_chan   (csr_chan),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .eff_count  (eff_count)
   );

   rws_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   rws_back #(
      .MAX_POPULATION (MAX_POPULATION)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_cmd   (pop_cmd),
      .eff_count (eff_count),
      .rsp_chan  (rsp_chan)
   );

endmodule

[sim/testbench.sv]
// ---------------------------------------------------------------------------
// Roulette wheel selection: testbench
// Loads fitness values and sends draws through the request channel. A
// scoreboard keeps its own cumulative sum wheel and predicts each response.
// Both channels idle and stall at random, phase by phase. The population
// count is rewritten between phases, including the zero and saturated values.
// ---------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rws_pkg::*;

   localparam int SETTLE_CYCLES = 40;
   localparam int STALL_LIMIT   = 2000;
   localparam int PHASE_ITEMS   = 114;

   class wheel_scoreboard;
      typedef struct {
         logic [SEL_W-1:0] index;
         logic             zero;
      } pick_type;

      logic [SUM_W-1:0] running_sums [DEF_MAX_POPULATION];
      int unsigned      filled;
      logic [CFG_W-1:0] population;
      pick_type         expected_picks [$];
      int               errors;

      function new();
         filled     = 0;
         population = CFG_W'(RESET_POPULATION);
         errors     = 0;
      endfunction

      function int unsigned wheel_size();
         return (population < DEF_MAX_POPULATION) ? population : DEF_MAX_POPULATION;
      endfunction

      function void set_population(logic [CFG_W-1:0] value);
         population = value;
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction

      function pick_type pick_entry(logic [DRAW_W-1:0] draw);
         pick_type          pick;
         int unsigned       n;
         logic [PROD_W-1:0] point;
         pick.index = '0;
         pick.zero  = 1'b0;
         n = (filled < wheel_size()) ? filled : wheel_size();
         if (n == 0) begin
            pick.zero = 1'b1;
         end else if (running_sums[n-1] == '0) begin
            pick.zero = 1'b1;
         end else begin
            point      = PROD_W'(draw) * PROD_W'(running_sums[n-1]);
            pick.index = SEL_W'(n - 1);
            for (int i = int'(n) - 1; i >= 0; i--) begin
               if (point < PROD_W'(running_sums[i]) * PROD_W'(SCALE))
                  pick.index = SEL_W'(i);
            end
         end
         return pick;
      endfunction

      function void note_request(cmd_kind_type kind, logic restart,
                                 logic [FIT_W-1:0] fitness, logic [DRAW_W-1:0] draw);
         logic [SUM_W:0] sum;
         if (kind == CMD_LOAD) begin
            if (restart)
               filled = 0;
            if (filled < wheel_size()) begin
               sum = (filled == 0) ? '0 : {1'b0, running_sums[filled-1]};
               sum = sum + fitness;
               running_sums[filled] = sum[SUM_W] ? SUM_MAX : sum[SUM_W-1:0];
               filled++;
            end
         end else begin
            expected_picks.push_back(pick_entry(draw));
         end
      endfunction

      function void check_result(logic [SEL_W-1:0] index, logic zero);
         pick_type want;
         if (expected_picks.size() == 0) begin
            $error("unexpected response: selected_index %0d zero_total %0d", index, zero);
            errors++;
            return;
         end
         want = expected_picks.pop_front();
         if (index !== want.index) begin
            $error("selected_index: expected %0d, actual %0d", want.index, index);
            errors++;
         end
         if (zero !== want.zero) begin
            $error("zero_total: expected %0d, actual %0d", want.zero, zero);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   rws_req_if req_chan();
   rws_rsp_if rsp_chan();
   rws_csr_if csr_chan();

   wheel_scoreboard wheel_sb;
   int              sender_idle_pct;
   int              receiver_stall_pct;
   int              watchdog_cycles;

   roulette_wheel_selection i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         wheel_sb.check_result(rsp_chan.selected_index, rsp_chan.zero_total);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         watchdog_cycles <= 0;
      end else if (watchdog_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         watchdog_cycles <= watchdog_cycles + 1;
      end
   end

   function automatic logic [FIT_W-1:0] random_fitness();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         2:       return FIT_W'($urandom_range(0, 15));
         3:       return FIT_W'($urandom_range(1 << 12, 1 << 18));
         default: return FIT_W'($urandom_range(0, (1 << FIT_W) - 1));
      endcase
   endfunction

   function automatic logic [DRAW_W-1:0] random_draw();
      case ($urandom_range(9))
         0:       return '0;
         1:       return DRAW_W'(SCALE - 1);
         2:       return DRAW_W'($urandom_range(SCALE, (1 << DRAW_W) - 1));
         default: return DRAW_W'($urandom_range(0, SCALE - 1));
      endcase
   endfunction

   task automatic send_request(cmd_kind_type kind, logic restart,
                               logic [FIT_W-1:0] fitness, logic [DRAW_W-1:0] draw);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_chan.valid         <= 1'b1;
      req_chan.mode          <= kind;
      req_chan.restart       <= restart;
      req_chan.fitness_value <= fitness;
      req_chan.draw          <= draw;
      do @(posedge clock); while (!req_chan.ready);
      wheel_sb.note_request(kind, restart, fitness, draw);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      while (wheel_sb.pending() != 0)
         @(posedge clock);
   endtask

   task automatic write_population(logic [CFG_W-1:0] value);
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_chan.valid            <= 1'b1;
      csr_chan.population_count <= value;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      wheel_sb.set_population(value);
   endtask

   task automatic run_phase(int budget);
      int          counted;
      int          loads;
      int          draws;
      int unsigned wheel_len;
      bit          all_zero;
      bit          paused;
      counted = 0;
      paused  = 1'b0;
      // draws first, against whatever wheel the previous phase left
      repeat (3) begin
         send_request(CMD_DRAW, 1'($urandom_range(1)), random_fitness(), random_draw());
         counted++;
      end
      while (counted < budget) begin
         if (!paused && counted > budget / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         if ($urandom_range(99) < 80) begin
            wheel_len = wheel_sb.wheel_size();
            loads     = $urandom_range(0, wheel_len);
            if ($urandom_range(9) == 0)
               loads += 2;
            all_zero = ($urandom_range(15) == 0);
            for (int j = 0; j < loads; j++) begin
               send_request(CMD_LOAD, j == 0, all_zero ? '0 : random_fitness(), random_draw());
               if (j < int'(wheel_len))
                  counted++;
            end
            draws = $urandom_range(1, 6);
            repeat (draws) begin
               send_request(CMD_DRAW, 1'($urandom_range(1)), random_fitness(), random_draw());
               counted++;
            end
         end else begin
            send_request(cmd_kind_type'($urandom_range(1)), 1'($urandom_range(1)),
                         FIT_W'($urandom_range(0, (1 << FIT_W) - 1)),
                         DRAW_W'($urandom_range(0, (1 << DRAW_W) - 1)));
            counted++;
         end
      end
   endtask

   initial begin
      logic [CFG_W-1:0] phase_counts [9];
      wheel_sb                  = new();
      reset                     = 1'b1;
      req_chan.valid            = 1'b0;
      req_chan.mode             = CMD_LOAD;
      req_chan.restart          = 1'b0;
      req_chan.fitness_value    = '0;
      req_chan.draw             = '0;
      csr_chan.valid            = 1'b0;
      csr_chan.population_count = '0;
      sender_idle_pct           = 0;
      receiver_stall_pct        = 0;
      phase_counts = '{6'd25, 6'd1, 6'd32, 6'd63, 6'd0, 6'd2, 6'd17,
                       CFG_W'($urandom_range(3, 31)), 6'd32};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // empty wheel, zero total, extremes of fitness and draw
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(500));
      send_request(CMD_LOAD, 1'b1, '0, '0);
      send_request(CMD_DRAW, 1'b0, '0, '0);
      send_request(CMD_LOAD, 1'b1, '1, '0);
      send_request(CMD_LOAD, 1'b0, '0, '0);
      send_request(CMD_LOAD, 1'b0, FIT_W'(1), '1);
      send_request(CMD_DRAW, 1'b0, '0, '0);
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(SCALE - 1));
      send_request(CMD_DRAW, 1'b0, '1, DRAW_W'(SCALE));
      send_request(CMD_DRAW, 1'b1, '0, '1);

      // loads past the population count are dropped
      write_population(CFG_W'(1));
      send_request(CMD_LOAD, 1'b1, FIT_W'(7), '0);
      send_request(CMD_LOAD, 1'b0, FIT_W'(9), '0);
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(SCALE - 1));

      // count lowered below the loaded entries
      write_population(CFG_W'(5));
      send_request(CMD_LOAD, 1'b1, FIT_W'(100), '0);
      send_request(CMD_LOAD, 1'b0, FIT_W'(200), '0);
      send_request(CMD_LOAD, 1'b0, FIT_W'(300), '0);
      send_request(CMD_LOAD, 1'b0, FIT_W'(400), '0);
      write_population(CFG_W'(2));
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(SCALE - 1));
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(333));

      write_population(CFG_W'(0));
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(10));
      send_request(CMD_LOAD, 1'b1, FIT_W'(5), '0);

      write_population('1);
      send_request(CMD_DRAW, 1'b0, '0, DRAW_W'(700));
      send_request(CMD_LOAD, 1'b1, '1, '0);
      send_request(CMD_DRAW, 1'b0, '0, '1);

      for (int p = 0; p < 9; p++) begin
         write_population(phase_counts[p]);
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 73; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 73; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         run_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (wheel_sb.errors == 0 && wheel_sb.pending() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/rws_pkg.sv
hdl/rws_channel_if.sv
hdl/rws_front.sv
hdl/rws_queue.sv
hdl/rws_back.sv
hdl/roulette_wheel_selection.sv
sim/testbench.sv
